// ===== src/vicc_response_subcarrier_encoder_macros.svh =====
// Assertion helpers for the response subcarrier encoder.
// Each macro expects clk and rst_n in scope.
`ifndef VICC_RESPONSE_SUBCARRIER_ENCODER_MACROS_SVH
`define VICC_RESPONSE_SUBCARRIER_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition that must hold in the same cycle.
`define VRSE_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Check a condition that must hold in the next cycle.
`define VRSE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define VRSE_ASSERT_NOW(label, pre, post, msg)
`define VRSE_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== src/vrse_pkg.sv =====
package vrse_pkg;

    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int SEG_LEN_W = 11;
    localparam int BASE_W    = 9;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Input item codes
    localparam logic [MODE_W-1:0] MODE_DATA = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EOF  = 2'd2;

    // Segment kinds
    localparam logic [KIND_W-1:0] KIND_SILENCE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FC32    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FC28    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RATE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBCARRIER_MODE = 2'd1;

    // Unstretched lengths
    localparam logic [BASE_W-1:0] LEN_SILENCE    = 9'd256;
    localparam logic [BASE_W-1:0] LEN_FC32_BIT   = 9'd16;
    localparam logic [BASE_W-1:0] LEN_FC28_BIT   = 9'd18;
    localparam logic [BASE_W-1:0] LEN_FC32_FRAME = 9'd48;
    localparam logic [BASE_W-1:0] LEN_FC28_FRAME = 9'd54;

    localparam logic [IDX_W-1:0] LAST_DATA_IDX = 4'd15;

    typedef struct packed {
        logic low_rate;
        logic subcarrier_mode;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [SEG_LEN_W-1:0] length;
        logic                 last;
    } seg_t;

endpackage

// ===== src/vrse_cfg_regs.sv =====
module vrse_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vrse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    output vrse_pkg::cfg_t                 cfg
);
    import vrse_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Drop writes to unknown indexes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOW_RATE:        cfg_next.low_rate        = cfg_data;
                CFG_SUBCARRIER_MODE: cfg_next.subcarrier_mode = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/vrse_seg_gen.sv =====
module vrse_seg_gen (
    input  vrse_pkg::cfg_t              cfg,
    input  logic [vrse_pkg::MODE_W-1:0] mode,
    input  logic [vrse_pkg::BYTE_W-1:0] data_byte,
    input  logic [vrse_pkg::IDX_W-1:0]  idx,
    output vrse_pkg::seg_t              seg
);
    import vrse_pkg::*;

    logic [KIND_W-1:0] kind;
    logic [BASE_W-1:0] base;
    logic              valid;
    logic              last;
    logic [KIND_W-1:0] other_kind;
    logic [BASE_W-1:0] other_base;
    logic              bit_val;

    // Half of a bit that is not the fc/32 burst.
    assign other_kind = cfg.subcarrier_mode ? KIND_FC28 : KIND_SILENCE;
    assign other_base = cfg.subcarrier_mode ? LEN_FC28_BIT : LEN_SILENCE;
    assign bit_val    = data_byte[idx[3:1]];

    always_comb
    begin
        valid = 1'b1;
        last  = 1'b0;
        kind  = KIND_FC32;
        base  = LEN_FC32_BIT;
        case (mode)
            MODE_DATA:
            begin
                // A one leads with the other half, a zero ends with it.
                if (bit_val ^ idx[0])
                begin
                    kind = other_kind;
                    base = other_base;
                end
                last = (idx == LAST_DATA_IDX);
            end
            MODE_SOF:
            begin
                if (cfg.subcarrier_mode)
                begin
                    case (idx[1:0])
                        2'd0:
                        begin
                            kind = KIND_FC28;
                            base = LEN_FC28_FRAME;
                        end
                        2'd1:
                        begin
                            kind = KIND_FC32;
                            base = LEN_FC32_FRAME;
                        end
                        2'd2:
                        begin
                            kind = KIND_FC28;
                            base = LEN_FC28_BIT;
                        end
                        default:
                        begin
                            kind = KIND_FC32;
                            base = LEN_FC32_BIT;
                            last = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    case (idx[1:0])
                        2'd0:
                        begin
                            kind = KIND_FC32;
                            base = LEN_FC32_FRAME;
                        end
                        2'd1:
                        begin
                            kind = KIND_SILENCE;
                            base = LEN_SILENCE;
                        end
                        default:
                        begin
                            kind = KIND_FC32;
                            base = LEN_FC32_BIT;
                            last = 1'b1;
                        end
                    endcase
                end
            end
            MODE_EOF:
            begin
                case (idx[1:0])
                    2'd0:
                    begin
                        kind = KIND_FC32;
                        base = LEN_FC32_BIT;
                    end
                    2'd1:
                    begin
                        kind = other_kind;
                        base = other_base;
                    end
                    2'd2:
                    begin
                        kind = KIND_FC32;
                        base = LEN_FC32_FRAME;
                        last = !cfg.subcarrier_mode;
                    end
                    default:
                    begin
                        kind = KIND_FC28;
                        base = LEN_FC28_FRAME;
                        last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                valid = 1'b0;
                last  = 1'b1;
            end
        endcase
    end

    // Stretch by four at the low data rate.
    always_comb
    begin
        seg.valid = valid;
        seg.kind  = kind;
        seg.last  = last;
        if (cfg.low_rate)
        begin
            seg.length = {base, 2'b00};
        end
        else
        begin
            seg.length = {2'b00, base};
        end
    end

endmodule

// ===== src/vicc_response_subcarrier_encoder.sv =====
// A request is held in the input register; each of its segments then passes through
// the output register. Throughput: one segment per cycle from the segment generator into
// the output register while it can take one: 16 segments per data byte, 3 (single) or 4
// (dual) per SOF or EOF; an undefined mode yields no segment and is dropped.
// Reset: rst_n asynchronous, active low; clears handshake state and both
// configuration registers to 0.
`include "vicc_response_subcarrier_encoder_macros.svh"

module vicc_response_subcarrier_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vrse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                               cfg_data,
    // Input request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [vrse_pkg::MODE_W-1:0]        mode,
    input  logic [vrse_pkg::BYTE_W-1:0]        data_byte,
    // Segment output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [vrse_pkg::KIND_W-1:0]        segment_kind,
    output logic [vrse_pkg::SEG_LEN_W-1:0]     segment_length,
    output logic                               last_segment
);
    import vrse_pkg::*;

    cfg_t cfg;
    seg_t seg;

    // Input register: the request being expanded plus its segment index.
    logic              item_valid_reg;
    logic              item_valid_next;
    logic [MODE_W-1:0] mode_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;

    // Output register: one segment waiting for the consumer.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [SEG_LEN_W-1:0] length_reg;
    logic                 last_reg;

    logic in_accept;
    logic out_free;
    logic step;
    logic done;

    vrse_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Segment of the held request at the current index.
    vrse_seg_gen u_gen (
        .cfg       (cfg),
        .mode      (mode_reg),
        .data_byte (byte_reg),
        .idx       (idx_reg),
        .seg       (seg)
    );

    // Advance when the output register can take the segment; an undefined
    // mode has no segment and drops straight away.
    assign out_free  = !out_valid_reg || out_ready;
    assign step      = item_valid_reg && (!seg.valid || out_free);
    assign done      = step && (!seg.valid || seg.last);
    assign in_ready  = !item_valid_reg || done;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        idx_next        = idx_reg;
        if (in_accept)
        begin
            item_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (done)
        begin
            item_valid_next = 1'b0;
        end
        else if (step)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && seg.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the request payload on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode;
            byte_reg <= data_byte;
        end
    end

    // Load the next segment whenever the generator advances with one.
    always_ff @(posedge clk)
    begin
        if (step && seg.valid)
        begin
            kind_reg   <= seg.kind;
            length_reg <= seg.length;
            last_reg   <= seg.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign segment_kind   = kind_reg;
    assign segment_length = length_reg;
    assign last_segment   = last_reg;

    `VRSE_ASSERT_NOW(a_frame_idx_range, item_valid_reg && mode_reg != MODE_DATA, idx_reg <= 4'd3, "frame request index out of range")
    `VRSE_ASSERT_NEXT(a_accept_clears_idx, in_accept, item_valid_reg && idx_reg == 4'd0, "accepted request does not start at index zero")
    `VRSE_ASSERT_NEXT(a_step_advances, step && !done && !in_accept, item_valid_reg && idx_reg == $past(idx_reg) + 4'd1, "segment index did not advance")
    `VRSE_ASSERT_NOW(a_empty_drops, item_valid_reg && !seg.valid, in_ready, "request without segments was not dropped")

endmodule

// ===== sim/vrse_segment_monitor.sv =====
`timescale 1ns / 1ps

module vrse_segment_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [vrse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [vrse_pkg::MODE_W-1:0]    mode,
    input  logic [vrse_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [vrse_pkg::KIND_W-1:0]    segment_kind,
    input  logic [vrse_pkg::SEG_LEN_W-1:0] segment_length,
    input  logic                           last_segment,
    output int                             mismatch_count,
    output int                             segments_pending
);
    import vrse_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SEG_LEN_W-1:0] length;
        logic                 last;
    } segment_t;

    segment_t expected_segments[$];
    logic     rate_low;
    logic     dual_mode;

    initial
    begin
        mismatch_count   = 0;
        segments_pending = 0;
        rate_low         = 1'b0;
        dual_mode        = 1'b0;
    end

    // Low rate stretches every length by four.
    function automatic logic [SEG_LEN_W-1:0] stretch(input logic [BASE_W-1:0] base);
        return rate_low ? {base, 2'b00} : SEG_LEN_W'(base);
    endfunction

    function automatic void push_segment(input logic [KIND_W-1:0] kind,
                                         input logic [BASE_W-1:0] base);
        segment_t seg;
        seg.kind   = kind;
        seg.length = stretch(base);
        seg.last   = 1'b0;
        expected_segments.push_back(seg);
    endfunction

    // Manchester code one bit: the second half carries the fc/32 burst for a one.
    function automatic void push_bit(input logic one);
        if (dual_mode)
        begin
            if (one)
            begin
                push_segment(KIND_FC28, LEN_FC28_BIT);
                push_segment(KIND_FC32, LEN_FC32_BIT);
            end
            else
            begin
                push_segment(KIND_FC32, LEN_FC32_BIT);
                push_segment(KIND_FC28, LEN_FC28_BIT);
            end
        end
        else
        begin
            if (one)
            begin
                push_segment(KIND_SILENCE, LEN_SILENCE);
                push_segment(KIND_FC32, LEN_FC32_BIT);
            end
            else
            begin
                push_segment(KIND_FC32, LEN_FC32_BIT);
                push_segment(KIND_SILENCE, LEN_SILENCE);
            end
        end
    endfunction

    function automatic void encode_request(input logic [MODE_W-1:0] item_mode,
                                           input logic [BYTE_W-1:0] item_byte);
        int       first;
        segment_t tail;
        first = expected_segments.size();
        case (item_mode)
            MODE_DATA:
            begin
                for (int i = 0; i < BYTE_W; i++)
                    push_bit(item_byte[i]);
            end
            MODE_SOF:
            begin
                // single mode merges the leading bursts into one fc/32 run
                if (dual_mode)
                begin
                    push_segment(KIND_FC28, LEN_FC28_FRAME);
                    push_segment(KIND_FC32, LEN_FC32_FRAME);
                end
                else
                    push_segment(KIND_FC32, LEN_FC32_FRAME);
                push_bit(1'b1);
            end
            MODE_EOF:
            begin
                push_bit(1'b0);
                if (dual_mode)
                begin
                    push_segment(KIND_FC32, LEN_FC32_FRAME);
                    push_segment(KIND_FC28, LEN_FC28_FRAME);
                end
                else
                    push_segment(KIND_FC32, LEN_FC32_FRAME);
            end
            default:
            begin
            end
        endcase
        if (expected_segments.size() > first)
        begin
            tail      = expected_segments.pop_back();
            tail.last = 1'b1;
            expected_segments.push_back(tail);
        end
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_segment();
        segment_t want;
        if (expected_segments.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected segment, expected none, actual kind %0d length %0d last %0d",
                     $time, segment_kind, segment_length, last_segment);
        end
        else
        begin
            want = expected_segments.pop_front();
            compare_field("segment_kind", int'(want.kind), int'(segment_kind));
            compare_field("segment_length", int'(want.length), int'(segment_length));
            compare_field("last_segment", int'(want.last), int'(last_segment));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_low  = 1'b0;
            dual_mode = 1'b0;
            expected_segments.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                encode_request(mode, data_byte);
            if (out_valid && out_ready)
                check_segment();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOW_RATE:        rate_low  = cfg_data;
                    CFG_SUBCARRIER_MODE: dual_mode = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
        segments_pending = expected_segments.size();
    end

endmodule

// ===== sim/vicc_response_subcarrier_encoder_test.sv =====
`timescale 1ns / 1ps

module vicc_response_subcarrier_encoder_test;
    import vrse_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int RESET_CYCLES  = 12;
    // a request with an undefined mode yields nothing but still occupies the block
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 228;
    localparam int MAX_GAP       = 11;

    // codes outside the package lists
    localparam logic [MODE_W-1:0]    MODE_UNDEFINED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI  = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_level_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode;
    logic [BYTE_W-1:0]    data_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [KIND_W-1:0]    segment_kind;
    logic [SEG_LEN_W-1:0] segment_length;
    logic                 last_segment;

    int          mismatch_count;
    int          segments_pending;
    int          cycle_count;
    int          random_sent;
    idle_level_t in_idle;
    idle_level_t out_idle;

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    vicc_response_subcarrier_encoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .segment_kind   (segment_kind),
        .segment_length (segment_length),
        .last_segment   (last_segment)
    );

    // Watch all three channels, predict the segment stream and compare it.
    vrse_segment_monitor monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .segment_kind     (segment_kind),
        .segment_length   (segment_length),
        .last_segment     (last_segment),
        .mismatch_count   (mismatch_count),
        .segments_pending (segments_pending)
    );

    // Draw the wait before one request or one segment.
    // Sparse idling keeps most gaps at zero so back-to-back traffic still shows up.
    function automatic int draw_gap(input idle_level_t level);
        case (level)
            IDLE_FULL:   return $urandom_range(0, MAX_GAP);
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            default:     return 0;
        endcase
    endfunction

    // Present one request and hold it until the block takes it.
    // Returns right after the accepting rising edge; valid stays high so a
    // zero gap lets the next request follow without a bubble.
    task automatic send_request(input logic [MODE_W-1:0] req_mode,
                                input logic [BYTE_W-1:0] req_byte);
        int gap;
        gap = draw_gap(in_idle);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        mode      <= req_mode;
        data_byte <= req_byte;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted segment has come out, then let
    // the block finish any request that yields nothing.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (segments_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index, input logic value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Byte extremes, an alternating pattern, both frame marks and an
    // undefined mode carrying a full byte, then drain.
    task automatic run_directed();
        send_request(MODE_SOF, 8'h00);
        send_request(MODE_DATA, 8'h00);
        send_request(MODE_DATA, 8'hFF);
        send_request(MODE_DATA, 8'hA5);
        send_request(MODE_EOF, 8'hFF);
        send_request(MODE_UNDEFINED, 8'hFF);
        settle();
    endtask

    // Mostly well-formed frames with random content; the rest are frames
    // with a misplaced or missing mark and plain noise with undefined modes.
    task automatic send_frame();
        int                shape;
        int                count;
        logic [MODE_W-1:0] noise_mode;
        shape = $urandom_range(0, 9);
        count = $urandom_range(1, 4);
        if (shape < 8)
        begin
            send_request(MODE_SOF, BYTE_W'($urandom_range(0, 255)));
            repeat (count) send_request(MODE_DATA, BYTE_W'($urandom_range(0, 255)));
            send_request(MODE_EOF, BYTE_W'($urandom_range(0, 255)));
            random_sent += count + 2;
        end
        else if (shape == 8)
        begin
            repeat (count) send_request(MODE_DATA, BYTE_W'($urandom_range(0, 255)));
            send_request($urandom_range(0, 1) ? MODE_SOF : MODE_EOF,
                         BYTE_W'($urandom_range(0, 255)));
            random_sent += count + 1;
        end
        else
        begin
            repeat (count)
            begin
                noise_mode = MODE_W'($urandom_range(0, 3));
                send_request(noise_mode, BYTE_W'($urandom_range(0, 255)));
                if (noise_mode != MODE_UNDEFINED)
                    random_sent++;
            end
        end
    endtask

    // Output side: stall before each segment, switching the idle pattern
    // every 32 segments so both busy and quiet stretches occur.
    initial
    begin : ready_driver
        int stall;
        int served;
        served    = 0;
        out_idle  = IDLE_NONE;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (served % 32 == 0)
                out_idle = idle_level_t'($urandom_range(0, 2));
            stall = draw_gap(out_idle);
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            served++;
        end
    end

    // Hard stop if the run hangs.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        // hold every input at a known value through reset
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_LOW_RATE;
        cfg_data    = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_DATA;
        data_byte   = '0;
        in_idle     = IDLE_NONE;
        random_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: high rate, single subcarrier
        run_directed();

        // low rate, dual subcarrier
        in_idle = IDLE_SPARSE;
        write_register(CFG_LOW_RATE, 1'b1);
        write_register(CFG_SUBCARRIER_MODE, 1'b1);
        run_directed();

        // writes to indexes past the list must leave both settings alone
        in_idle = IDLE_FULL;
        write_register(CFG_UNUSED_LO, 1'b0);
        write_register(CFG_UNUSED_HI, 1'b0);
        write_register(CFG_LOW_RATE, 1'b0);
        run_directed();

        // low rate, single subcarrier
        in_idle = IDLE_NONE;
        write_register(CFG_LOW_RATE, 1'b1);
        write_register(CFG_SUBCARRIER_MODE, 1'b0);
        run_directed();

        // random phases: new settings and idle pattern, a few frames, drain
        while (random_sent < RANDOM_ITEMS)
        begin
            write_register(CFG_LOW_RATE, 1'($urandom_range(0, 1)));
            write_register(CFG_SUBCARRIER_MODE, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                               1'($urandom_range(0, 1)));
            in_idle = idle_level_t'($urandom_range(0, 2));
            repeat (4) send_frame();
            settle();
        end

        // let any stray segment show up before the verdict
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && segments_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
